// ===== rtl/nhb_pkg.sv =====
`timescale 1ns / 1ps
package nhb_pkg;

  // frame store geometry
  localparam int MAX_PIXELS = 1024;
  localparam int PIX_W      = $clog2(MAX_PIXELS);
  localparam int STRIP_W    = PIX_W + 1;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes
  localparam logic [2:0] REG_HUE_A      = 3'd0;
  localparam logic [2:0] REG_HUE_B      = 3'd1;
  localparam logic [2:0] REG_BLEND      = 3'd2;
  localparam logic [2:0] REG_MIN_BRIGHT = 3'd3;
  localparam logic [2:0] REG_MIN_SAT    = 3'd4;
  localparam logic [2:0] REG_MAX_SAT    = 3'd5;
  localparam logic [2:0] REG_MAX_BRIGHT = 3'd6;
  localparam logic [2:0] REG_STRIP_LEN  = 3'd7;

  // register reset values
  localparam logic [7:0]         RST_HUE_A      = 8'd81;
  localparam logic [7:0]         RST_HUE_B      = 8'd225;
  localparam logic [7:0]         RST_BLEND      = 8'd150;
  localparam logic [7:0]         RST_MIN_BRIGHT = 8'd245;
  localparam logic [7:0]         RST_MIN_SAT    = 8'd215;
  localparam logic [7:0]         RST_MAX_SAT    = 8'd255;
  localparam logic [7:0]         RST_MAX_BRIGHT = 8'd255;
  localparam logic [STRIP_W-1:0] RST_STRIP_LEN  = STRIP_W'(MAX_PIXELS);

  // noise full scale and hue sector bounds (hue times six)
  localparam logic [16:0] NOISE_FULL = 17'd65535;
  localparam logic [10:0] SECT_1     = 11'd255;
  localparam logic [10:0] SECT_2     = 11'd510;
  localparam logic [10:0] SECT_3     = 11'd765;
  localparam logic [10:0] SECT_4     = 11'd1020;
  localparam logic [10:0] SECT_5     = 11'd1275;
  localparam logic [10:0] SECT_6     = 11'd1530;
  localparam logic [8:0]  CHAN_FULL  = 9'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic [15:0]      noise_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       index_error;
  } out_word_t;

  // floor(p / 65535) for p up to 255 * 65535
  function automatic logic [7:0] div_full(input logic [23:0] p);
    logic [7:0]  q0;
    logic [16:0] r;
    q0 = p[23:16];
    r  = {1'b0, p[15:0]} + {9'b0, q0};
    return q0 + {7'b0, (r >= NOISE_FULL)};
  endfunction

  // floor(p / 255) for p up to 255 * 255
  function automatic logic [7:0] div_chan(input logic [15:0] p);
    logic [7:0] q0;
    logic [8:0] r;
    q0 = p[15:8];
    r  = {1'b0, p[7:0]} + {1'b0, q0};
    return q0 + {7'b0, (r >= CHAN_FULL)};
  endfunction

  // magnitude and sign of hi - lo
  function automatic logic [8:0] span_of(input logic [7:0] lo, input logic [7:0] hi);
    logic [8:0] d;
    logic [8:0] m;
    d = {1'b0, hi} - {1'b0, lo};
    m = d[8] ? (9'd0 - d) : d;
    return {d[8], m[7:0]};
  endfunction

  // six-sector hue wheel, returns {r, g, b}
  function automatic logic [23:0] hue_wheel(input logic [7:0] h);
    logic [10:0] h6;
    logic [10:0] r;
    logic [10:0] g;
    logic [10:0] b;
    h6 = {1'b0, h, 2'b0} + {2'b0, h, 1'b0};
    r  = '0;
    g  = '0;
    b  = '0;
    if (h6 < SECT_2) begin
      if (h6 < SECT_1) begin
        r = SECT_1;
        g = h6;
      end else begin
        r = SECT_2 - h6;
        g = SECT_1;
      end
    end else if (h6 < SECT_4) begin
      if (h6 < SECT_3) begin
        g = SECT_1;
        b = h6 - SECT_2;
      end else begin
        g = SECT_4 - h6;
        b = SECT_1;
      end
    end else if (h6 < SECT_6) begin
      if (h6 < SECT_5) begin
        r = h6 - SECT_4;
        b = SECT_1;
      end else begin
        r = SECT_1;
        b = SECT_6 - h6;
      end
    end else begin
      r = SECT_1;
    end
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  // first half of saturation scaling: (c * (s + 1)) >> 8 plus 255 - s
  function automatic logic [8:0] sat_scale(input logic [7:0] c, input logic [7:0] s);
    logic [16:0] p;
    p = {9'b0, c} * ({8'b0, s} + 17'd1);
    return {1'b0, p[15:8]} + {1'b0, ~s};
  endfunction

  // second half: (t * (v + 1)) >> 8, low byte
  function automatic logic [7:0] val_scale(input logic [8:0] t, input logic [7:0] v);
    logic [17:0] p;
    p = {9'b0, t} * ({10'b0, v} + 18'd1);
    return p[15:8];
  endfunction

  // move old toward tgt by amt / 255, truncating toward zero
  function automatic logic [7:0] mix_chan(input logic [7:0] old, input logic [7:0] tgt,
                                          input logic [7:0] amt);
    logic [8:0]  d;
    logic [8:0]  m;
    logic [15:0] p;
    logic [7:0]  q;
    d = {1'b0, tgt} - {1'b0, old};
    m = d[8] ? (9'd0 - d) : d;
    p = {8'b0, m[7:0]} * {8'b0, amt};
    q = div_chan(p);
    return d[8] ? (old - q) : (old + q);
  endfunction

endpackage

// ===== rtl/noise_to_hsv_color_frame_blender.sv =====
`timescale 1ns / 1ps
// throughput: one word per cycle, seven register stages with per-stage stall
// the frame store read-modify-write closes in stage six with a bypass from the output register
// reset: synchronous active-low, control and configuration registers go to their reset values
// a clearing pass over all 1024 store entries (one store entry a cycle) then runs with in_ready low
// a new strip_length restarts the clearing pass
module noise_to_hsv_color_frame_blender
  import nhb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // configuration registers
  logic [7:0]         hue_a_r, hue_b_r, blend_r, min_bright_r, min_sat_r;
  logic [7:0]         max_sat_r, max_bright_r;
  logic [STRIP_W-1:0] strip_len_r;

  // clearing pass
  logic             clr_busy_r;
  logic [PIX_W-1:0] clr_addr_r;

  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic             strip_change;

  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx      = cfg_paddr[4:2];
  assign strip_change = cfg_wr && (cfg_idx == REG_STRIP_LEN)
                        && (cfg_pwdata[STRIP_W-1:0] != strip_len_r);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_a_r      <= RST_HUE_A;
      hue_b_r      <= RST_HUE_B;
      blend_r      <= RST_BLEND;
      min_bright_r <= RST_MIN_BRIGHT;
      min_sat_r    <= RST_MIN_SAT;
      max_sat_r    <= RST_MAX_SAT;
      max_bright_r <= RST_MAX_BRIGHT;
      strip_len_r  <= RST_STRIP_LEN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HUE_A:      hue_a_r      <= cfg_pwdata[7:0];
        REG_HUE_B:      hue_b_r      <= cfg_pwdata[7:0];
        REG_BLEND:      blend_r      <= cfg_pwdata[7:0];
        REG_MIN_BRIGHT: min_bright_r <= cfg_pwdata[7:0];
        REG_MIN_SAT:    min_sat_r    <= cfg_pwdata[7:0];
        REG_MAX_SAT:    max_sat_r    <= cfg_pwdata[7:0];
        REG_MAX_BRIGHT: max_bright_r <= cfg_pwdata[7:0];
        REG_STRIP_LEN:  strip_len_r  <= cfg_pwdata[STRIP_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    cfg_prdata = '0;
    case (cfg_idx)
      REG_HUE_A:      cfg_prdata = {24'b0, hue_a_r};
      REG_HUE_B:      cfg_prdata = {24'b0, hue_b_r};
      REG_BLEND:      cfg_prdata = {24'b0, blend_r};
      REG_MIN_BRIGHT: cfg_prdata = {24'b0, min_bright_r};
      REG_MIN_SAT:    cfg_prdata = {24'b0, min_sat_r};
      REG_MAX_SAT:    cfg_prdata = {24'b0, max_sat_r};
      REG_MAX_BRIGHT: cfg_prdata = {24'b0, max_bright_r};
      REG_STRIP_LEN:  cfg_prdata = {{(CFG_DW-STRIP_W){1'b0}}, strip_len_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // clearing pass sweeps the store after reset and after a strip length change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (strip_change) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == PIX_W'(MAX_PIXELS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // stage valids and loads
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r, vld7_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;
  logic in_acc;

  assign ld7      = !vld7_r || out_ready;
  assign ld6      = !vld6_r || ld7;
  assign ld5      = !vld5_r || ld6;
  assign ld4      = !vld4_r || ld5;
  assign ld3      = !vld3_r || ld4;
  assign ld2      = !vld2_r || ld3;
  assign ld1      = !vld1_r || ld2;
  assign in_ready = ld1 && !clr_busy_r;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      if (ld1) vld1_r <= in_acc;
      if (ld2) vld2_r <= vld1_r;
      if (ld3) vld3_r <= vld2_r;
      if (ld4) vld4_r <= vld3_r;
      if (ld5) vld5_r <= vld4_r;
      if (ld6) vld6_r <= vld5_r;
      if (ld7) vld7_r <= vld6_r;
    end
  end

  // stage 1: input register and range check
  logic [PIX_W-1:0] idx1_r;
  logic [15:0]      noise1_r;
  logic             err1_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      idx1_r   <= in_data.pixel_index;
      noise1_r <= in_data.noise_value;
      err1_r   <= ({1'b0, in_data.pixel_index} >= strip_len_r);
    end
  end

  // stage 2: noise times span magnitude for hue, saturation and value
  logic [8:0]       span_h, span_s, span_v;
  logic [PIX_W-1:0] idx2_r;
  logic             err2_r;
  logic [23:0]      ph2_r, ps2_r, pv2_r;

  assign span_h = span_of(hue_a_r, hue_b_r);
  assign span_s = span_of(min_sat_r, max_sat_r);
  assign span_v = span_of(min_bright_r, max_bright_r);

  always_ff @(posedge clk) begin
    if (ld2) begin
      idx2_r <= idx1_r;
      err2_r <= err1_r;
      ph2_r  <= {8'b0, noise1_r} * {16'b0, span_h[7:0]};
      ps2_r  <= {8'b0, noise1_r} * {16'b0, span_s[7:0]};
      pv2_r  <= {8'b0, noise1_r} * {16'b0, span_v[7:0]};
    end
  end

  // stage 3: divide by full scale, apply sign, add the low end
  logic [7:0]       qh, qs, qv;
  logic [PIX_W-1:0] idx3_r;
  logic             err3_r;
  logic [7:0]       hue3_r, sat3_r, bri3_r;

  assign qh = div_full(ph2_r);
  assign qs = div_full(ps2_r);
  assign qv = div_full(pv2_r);

  always_ff @(posedge clk) begin
    if (ld3) begin
      idx3_r <= idx2_r;
      err3_r <= err2_r;
      hue3_r <= span_h[8] ? (hue_a_r - qh) : (hue_a_r + qh);
      sat3_r <= span_s[8] ? (min_sat_r - qs) : (min_sat_r + qs);
      bri3_r <= span_v[8] ? (min_bright_r - qv) : (min_bright_r + qv);
    end
  end

  // stage 4: hue sector to raw channels
  logic [PIX_W-1:0] idx4_r;
  logic             err4_r;
  logic [23:0]      raw4_r;
  logic [7:0]       sat4_r, bri4_r;

  always_ff @(posedge clk) begin
    if (ld4) begin
      idx4_r <= idx3_r;
      err4_r <= err3_r;
      raw4_r <= hue_wheel(hue3_r);
      sat4_r <= sat3_r;
      bri4_r <= bri3_r;
    end
  end

  // stage 5: saturation scaling
  logic [PIX_W-1:0] idx5_r;
  logic             err5_r;
  logic [8:0]       tr5_r, tg5_r, tb5_r;
  logic [7:0]       bri5_r;

  always_ff @(posedge clk) begin
    if (ld5) begin
      idx5_r <= idx4_r;
      err5_r <= err4_r;
      tr5_r  <= sat_scale(raw4_r[23:16], sat4_r);
      tg5_r  <= sat_scale(raw4_r[15:8], sat4_r);
      tb5_r  <= sat_scale(raw4_r[7:0], sat4_r);
      bri5_r <= bri4_r;
    end
  end

  // stage 6: value scaling, frame store read
  logic [PIX_W-1:0] idx6_r;
  logic             err6_r;
  logic [23:0]      tgt6_r;
  logic [23:0]      mem_q_r;
  logic [23:0]      frame_mem [MAX_PIXELS];

  always_ff @(posedge clk) begin
    if (ld6) begin
      idx6_r <= idx5_r;
      err6_r <= err5_r;
      tgt6_r <= {val_scale(tr5_r, bri5_r), val_scale(tg5_r, bri5_r),
                 val_scale(tb5_r, bri5_r)};
    end
  end

  always_ff @(posedge clk) begin
    if (ld6) begin
      mem_q_r <= frame_mem[idx5_r];
    end
  end

  // blend toward target, bypassing the word just written back
  logic [PIX_W-1:0] idx7_r;
  logic [7:0]       amt;
  logic             fwd;
  logic [23:0]      old6;
  logic [23:0]      mix6;
  out_word_t        out7_r;

  assign amt  = (blend_r == 8'd0) ? 8'd1 : blend_r;
  assign fwd  = vld7_r && !out7_r.index_error && (idx7_r == idx6_r);
  assign old6 = fwd ? {out7_r.red, out7_r.green, out7_r.blue} : mem_q_r;
  assign mix6 = {mix_chan(old6[23:16], tgt6_r[23:16], amt),
                 mix_chan(old6[15:8], tgt6_r[15:8], amt),
                 mix_chan(old6[7:0], tgt6_r[7:0], amt)};

  // stage 7: output register
  always_ff @(posedge clk) begin
    if (ld7) begin
      idx7_r <= idx6_r;
      if (err6_r) begin
        out7_r <= '{red: 8'd0, green: 8'd0, blue: 8'd0, index_error: 1'b1};
      end else begin
        out7_r <= '{red: mix6[23:16], green: mix6[15:8], blue: mix6[7:0],
                    index_error: 1'b0};
      end
    end
  end

  assign out_valid = vld7_r;
  assign out_data  = out7_r;

  // store write port: clearing pass first, then write-back
  logic             mem_we;
  logic [PIX_W-1:0] mem_wa;
  logic [23:0]      mem_wd;

  always_comb begin
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else begin
      mem_we = ld7 && vld6_r && !err6_r;
      mem_wa = idx6_r;
      mem_wd = mix6;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
  end

  // checks
  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |->
      out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0)
    else $error("flagged index word carries a color");

  a_strip_clear: assert property (@(posedge clk) disable iff (!rst_n)
    strip_change |=> clr_busy_r && clr_addr_r == '0)
    else $error("strip length change did not start the clearing pass");

  a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r && clr_addr_r == PIX_W'(MAX_PIXELS - 1) |=>
      !clr_busy_r || clr_addr_r == '0)
    else $error("clearing pass ran past the last entry");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld1_r)
    else $error("accepted word lost at the first stage");

endmodule

// ===== tb/noise_to_hsv_color_frame_blender_tb.sv =====
`timescale 1ns / 1ps
module noise_to_hsv_color_frame_blender_tb
  import nhb_pkg::*;
();

  // expected color per pixel word, with its own copy of registers and frame store
  class pixel_color_predictor;
    bit [7:0]         hue_lo;
    bit [7:0]         hue_hi;
    bit [7:0]         blend;
    bit [7:0]         bright_lo;
    bit [7:0]         bright_hi;
    bit [7:0]         sat_lo;
    bit [7:0]         sat_hi;
    bit [STRIP_W-1:0] strip_len;
    bit [23:0]        frame [MAX_PIXELS];
    out_word_t        expected_colors [$];
    int               fail_count;

    function new();
      hue_lo     = RST_HUE_A;
      hue_hi     = RST_HUE_B;
      blend      = RST_BLEND;
      bright_lo  = RST_MIN_BRIGHT;
      bright_hi  = RST_MAX_BRIGHT;
      sat_lo     = RST_MIN_SAT;
      sat_hi     = RST_MAX_SAT;
      strip_len  = RST_STRIP_LEN;
      fail_count = 0;
      foreach (frame[i]) frame[i] = '0;
    endfunction

    // register write as seen by the block
    function void update_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_HUE_A:      hue_lo    = value[7:0];
        REG_HUE_B:      hue_hi    = value[7:0];
        REG_BLEND:      blend     = value[7:0];
        REG_MIN_BRIGHT: bright_lo = value[7:0];
        REG_MIN_SAT:    sat_lo    = value[7:0];
        REG_MAX_SAT:    sat_hi    = value[7:0];
        REG_MAX_BRIGHT: bright_hi = value[7:0];
        REG_STRIP_LEN: begin
          // only a changed length wipes the store
          if (value[STRIP_W-1:0] != strip_len) begin
            foreach (frame[i]) frame[i] = '0;
            strip_len = value[STRIP_W-1:0];
          end
        end
        default: ;
      endcase
    endfunction

    // linear map of the noise onto lo..hi, truncating toward zero
    function bit [7:0] map_noise(bit [15:0] n, bit [7:0] lo, bit [7:0] hi);
      int span;
      int q;
      span = int'(hi) - int'(lo);
      q = (int'(n) * span) / 65535 + int'(lo);
      return q[7:0];
    endfunction

    // saturation then value scaling of one channel
    function bit [7:0] scale_chan(int c, int s, int v);
      int t;
      int p;
      t = ((c * (s + 1)) >> 8) + (255 - s);
      p = (t * (v + 1)) >> 8;
      return p[7:0];
    endfunction

    // step the stored channel toward the target by amt / 255
    function bit [7:0] step_chan(bit [7:0] prev, bit [7:0] tgt, int amt);
      int d;
      int sum;
      d = ((int'(tgt) - int'(prev)) * amt) / 255;
      sum = int'(prev) + d;
      return sum[7:0];
    endfunction

    function void note_pixel(in_word_t w);
      out_word_t exp_word;
      bit [7:0]  h;
      bit [7:0]  s;
      bit [7:0]  v;
      int        h6;
      int        r;
      int        g;
      int        b;
      int        amt;
      bit [23:0] old_rgb;
      exp_word = '0;
      if ({1'b0, w.pixel_index} >= strip_len) begin
        exp_word.index_error = 1'b1;
        expected_colors.push_back(exp_word);
        return;
      end
      h = map_noise(w.noise_value, hue_lo, hue_hi);
      s = map_noise(w.noise_value, sat_lo, sat_hi);
      v = map_noise(w.noise_value, bright_lo, bright_hi);
      // six hue sectors, anything past the last one is pure red
      h6 = int'(h) * 6;
      r = 0;
      g = 0;
      b = 0;
      if (h6 < 510) begin
        if (h6 < 255) begin
          r = 255;
          g = h6;
        end else begin
          r = 510 - h6;
          g = 255;
        end
      end else if (h6 < 1020) begin
        if (h6 < 765) begin
          g = 255;
          b = h6 - 510;
        end else begin
          g = 1020 - h6;
          b = 255;
        end
      end else if (h6 < 1530) begin
        if (h6 < 1275) begin
          r = h6 - 1020;
          b = 255;
        end else begin
          r = 255;
          b = 1530 - h6;
        end
      end else begin
        r = 255;
      end
      // a zero blend amount behaves as one
      amt = (blend == 8'd0) ? 1 : int'(blend);
      old_rgb = frame[w.pixel_index];
      exp_word.red   = step_chan(old_rgb[23:16], scale_chan(r, s, v), amt);
      exp_word.green = step_chan(old_rgb[15:8], scale_chan(g, s, v), amt);
      exp_word.blue  = step_chan(old_rgb[7:0], scale_chan(b, s, v), amt);
      frame[w.pixel_index] = {exp_word.red, exp_word.green, exp_word.blue};
      expected_colors.push_back(exp_word);
    endfunction

    function void check_color(out_word_t got);
      out_word_t exp_word;
      if (expected_colors.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, got);
        fail_count++;
        return;
      end
      exp_word = expected_colors.pop_front();
      if (got.red !== exp_word.red) begin
        $display("%0t red: expected %0d, actual %0d", $time, exp_word.red, got.red);
        fail_count++;
      end
      if (got.green !== exp_word.green) begin
        $display("%0t green: expected %0d, actual %0d", $time, exp_word.green, got.green);
        fail_count++;
      end
      if (got.blue !== exp_word.blue) begin
        $display("%0t blue: expected %0d, actual %0d", $time, exp_word.blue, got.blue);
        fail_count++;
      end
      if (got.index_error !== exp_word.index_error) begin
        $display("%0t index_error: expected %0b, actual %0b", $time,
                 exp_word.index_error, got.index_error);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_word_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  pixel_color_predictor colors = new();
  bit                   idle_on = 1'b1;
  logic [PIX_W-1:0]     last_pixel = '0;
  logic [PIX_W-1:0]     hot_pixels [4];

  noise_to_hsv_color_frame_blender DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (psel),
    .cfg_penable(penable),
    .cfg_pwrite (pwrite),
    .cfg_paddr  (paddr),
    .cfg_pwdata (pwdata),
    .cfg_prdata (prdata),
    .cfg_pready (pready)
  );

  always #4 clk = ~clk;

  // register write: setup cycle, then access until pready; unused data bits are random
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] data;
    data = $urandom();
    if (idx == REG_STRIP_LEN) data[STRIP_W-1:0] = value[STRIP_W-1:0];
    else data[7:0] = value[7:0];
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    colors.update_reg(idx, data);
  endtask

  task automatic write_all(input logic [7:0] h_a, input logic [7:0] h_b,
                           input logic [7:0] amt, input logic [7:0] v_lo,
                           input logic [7:0] s_lo, input logic [7:0] s_hi,
                           input logic [7:0] v_hi, input logic [10:0] len);
    write_reg(REG_HUE_A, {24'b0, h_a});
    write_reg(REG_HUE_B, {24'b0, h_b});
    write_reg(REG_BLEND, {24'b0, amt});
    write_reg(REG_MIN_BRIGHT, {24'b0, v_lo});
    write_reg(REG_MIN_SAT, {24'b0, s_lo});
    write_reg(REG_MAX_SAT, {24'b0, s_hi});
    write_reg(REG_MAX_BRIGHT, {24'b0, v_hi});
    write_reg(REG_STRIP_LEN, {21'b0, len});
  endtask

  // block idle: all colors back, then wait until the pipeline has emptied
  task automatic drain();
    while (colors.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // one pixel word, with an occasional idle burst ahead of it
  task automatic push_pixel(input logic [PIX_W-1:0] idx, input logic [15:0] noise);
    in_word_t w;
    w.pixel_index = idx;
    w.noise_value = noise;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    colors.note_pixel(w);
    last_pixel = idx;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic random_setting();
    logic [7:0]  amt;
    logic [10:0] len;
    int          limit;
    case ($urandom_range(0, 4))
      0:       amt = 8'd0;
      1:       amt = 8'd1;
      2:       amt = 8'd255;
      default: amt = 8'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0:       len = 11'd0;
      1:       len = 11'd1;
      2:       len = 11'd1023;
      3:       len = 11'd1024;
      4:       len = 11'd2047;
      5:       len = colors.strip_len;
      default: len = 11'($urandom_range(2, 1023));
    endcase
    write_all(pick_byte(), pick_byte(), amt, pick_byte(), pick_byte(), pick_byte(),
              pick_byte(), len);
    // a few pixels that get hit over and over
    limit = (colors.strip_len > MAX_PIXELS) ? MAX_PIXELS : int'(colors.strip_len);
    foreach (hot_pixels[i])
      hot_pixels[i] = (limit == 0) ? PIX_W'($urandom()) : PIX_W'($urandom_range(0, limit - 1));
  endtask

  task automatic random_pixels(input int count);
    logic [PIX_W-1:0] idx;
    logic [15:0]      noise;
    int               limit;
    limit = (colors.strip_len > MAX_PIXELS) ? MAX_PIXELS : int'(colors.strip_len);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: idx = hot_pixels[$urandom_range(0, 3)];
        4, 5, 6, 7: idx = (limit == 0) ? PIX_W'($urandom())
                                       : PIX_W'($urandom_range(0, limit - 1));
        8:          idx = PIX_W'($urandom());
        default:    idx = last_pixel;
      endcase
      case ($urandom_range(0, 9))
        0:       noise = 16'h0000;
        1:       noise = 16'hFFFF;
        default: noise = 16'($urandom());
      endcase
      push_pixel(idx, noise);
    end
  endtask

  // result side: check accepted words, stall in short random bursts while idle_on is set
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) colors.check_color(out_data);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    int h_pts [9];
    h_pts = '{0, 42, 43, 85, 128, 170, 212, 213, 255};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: noise extremes, both ends of the strip, repeated pixel
    push_pixel(10'd0, 16'h0000);
    push_pixel(10'd0, 16'hFFFF);
    push_pixel(10'd1023, 16'hFFFF);
    push_pixel(10'd1023, 16'h0000);
    push_pixel(10'd5, 16'h5555);
    push_pixel(10'd5, 16'hAAAA);
    push_pixel(10'd5, 16'h8000);
    in_valid <= 1'b0;
    drain();

    // full ranges, same strip length rewritten; walk the hue sector edges up to pure red
    write_all(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 11'd1024);
    foreach (h_pts[i]) push_pixel(PIX_W'(100 + i), 16'(h_pts[i] * 257));
    in_valid <= 1'b0;
    drain();

    // falling ranges, zero blend amount, short strip with out-of-range indexes
    write_all(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 11'd10);
    push_pixel(10'd9, 16'h0000);
    push_pixel(10'd9, 16'd40000);
    push_pixel(10'd10, 16'h0001);
    push_pixel(10'd1023, 16'h0002);
    in_valid <= 1'b0;
    drain();

    // empty strip rejects everything
    write_all(8'd17, 8'd200, 8'd1, 8'd30, 8'd60, 8'd90, 8'd120, 11'd0);
    push_pixel(10'd0, 16'd123);
    push_pixel(10'd512, 16'hFFFF);
    in_valid <= 1'b0;
    drain();

    // random settings with random pixel streams
    repeat (8) begin
      random_setting();
      random_pixels(135);
      in_valid <= 1'b0;
      drain();
    end

    // last stretch at full rate
    idle_on = 1'b0;
    random_setting();
    random_pixels(140);
    in_valid <= 1'b0;
    drain();

    if (colors.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nhb_pkg.sv
rtl/noise_to_hsv_color_frame_blender.sv
tb/noise_to_hsv_color_frame_blender_tb.sv
